>>> src/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 decoder package
// Beat types, status codes and the symbol lookup shared by the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LENGTH  = 2'd1;
    localparam logic [1:0] ST_BADCHAR = 2'd2;

    localparam logic [6:0] SYM_INVALID = 7'h40;
    localparam logic [6:0] SYM_PLUS    = 7'h3E;
    localparam logic [6:0] SYM_SLASH   = 7'h3F;
    localparam logic [6:0] SYM_DIGIT0  = 7'h34;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } enc_beat_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_stream;
        logic [1:0] status;
    } dec_beat_t;

    // Result group caused by one character: up to three bytes plus end status.
    typedef struct packed {
        logic        emit;
        logic        has_bytes;
        logic [1:0]  last_idx;
        logic        eos;
        logic [1:0]  status;
        logic [23:0] bytes;
    } grp_t;

    function automatic logic [6:0] sym_value(input logic [7:0] c);
        logic [6:0] v;
        v = SYM_INVALID;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            v = 7'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            v = 7'(c - 8'h47);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 7'(c - 8'h30) + SYM_DIGIT0;
        end
        else if (c == CH_PLUS)
        begin
            v = SYM_PLUS;
        end
        else if (c == CH_SLASH)
        begin
            v = SYM_SLASH;
        end
        return v;
    endfunction

endpackage

>>> src/b64d_decode.sv
// ----------------------------------------------------------------------------
// Base64 decode step
// Quartet state and the per-character step that builds one result group.
// ----------------------------------------------------------------------------
module b64d_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  b64d_pkg::enc_beat_t beat,
    input  logic                accept,
    output b64d_pkg::grp_t      grp
);

    logic [23:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic [2:0]  pad_reg, pad_next;
    logic        bad_reg, bad_next;

    logic        space;
    logic        is_pad;
    logic [6:0]  sym;
    logic [1:0]  st;

    always_comb
    begin
        space  = (beat.char_code == b64d_pkg::CH_SPACE) || (beat.char_code == b64d_pkg::CH_TAB)
              || (beat.char_code == b64d_pkg::CH_CR) || (beat.char_code == b64d_pkg::CH_LF);
        is_pad = (beat.char_code == b64d_pkg::CH_PAD);
        sym    = b64d_pkg::sym_value(beat.char_code);
        st     = b64d_pkg::ST_OK;

        acc_next = acc_reg;
        pos_next = pos_reg;
        pad_next = pad_reg;
        bad_next = bad_reg;
        grp      = '0;

        if (!space)
        begin
            if (is_pad)
            begin
                if (pad_reg != 3'd7)
                begin
                    pad_next = pad_reg + 3'd1;
                end
            end
            else if (sym == b64d_pkg::SYM_INVALID)
            begin
                bad_next = 1'b1;
            end
            else
            begin
                acc_next = {acc_reg[17:0], sym[5:0]};
            end

            if (pos_reg == 2'd3)
            begin
                unique case (pad_next)
                    3'd0:    grp.bytes = acc_next;
                    3'd1:    grp.bytes = {acc_next[17:0], 6'b0};
                    3'd2:    grp.bytes = {acc_next[11:0], 12'b0};
                    3'd3:    grp.bytes = {acc_next[5:0], 18'b0};
                    default: grp.bytes = '0;
                endcase
                if (!bad_next)
                begin
                    grp.emit      = 1'b1;
                    grp.has_bytes = 1'b1;
                    grp.last_idx  = (pad_next == 3'd0) ? 2'd2 :
                                    (pad_next == 3'd1) ? 2'd1 : 2'd0;
                end
                acc_next = '0;
                pad_next = '0;
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end

        if (beat.last_char)
        begin
            // length error outranks a bad character
            if (pos_next != 2'd0)
            begin
                st = b64d_pkg::ST_LENGTH;
            end
            else if (bad_next)
            begin
                st = b64d_pkg::ST_BADCHAR;
            end
            grp.emit   = 1'b1;
            grp.eos    = 1'b1;
            grp.status = st;
            acc_next   = '0;
            pad_next   = '0;
            pos_next   = '0;
            bad_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            pad_reg <= '0;
            bad_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            pad_reg <= pad_next;
            bad_reg <= bad_next;
        end
    end

endmodule

>>> src/base64_decoder_unit.sv
// Latency: first result of a character is shown the cycle after its beat is taken.
// Throughput: one character per cycle while dec_stall is low; the output port
// moves one byte per cycle, so a character that closes a quartet with 2 or 3
// bytes holds enc_stall while the result register drains.
// Reset: rst_n clears the quartet state, the sticky error and the result register.
// ----------------------------------------------------------------------------
// Base64 decoder unit
// Streaming RFC 4648 decoder: one character in, zero to three bytes out.
// ----------------------------------------------------------------------------
module base64_decoder_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enc_valid,
    output logic                enc_stall,
    input  b64d_pkg::enc_beat_t enc_data,
    output logic                dec_valid,
    input  logic                dec_stall,
    output b64d_pkg::dec_beat_t dec_data
);

    b64d_pkg::grp_t grp;
    b64d_pkg::grp_t grp_reg;
    logic           busy_reg, busy_next;
    logic [1:0]     idx_reg, idx_next;

    logic           take;
    logic           at_last;
    logic           room;
    logic           enc_take;
    logic [7:0]     sel_byte;

    b64d_decode u_decode
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .beat   (enc_data),
        .accept (enc_take),
        .grp    (grp)
    );

    assign take     = busy_reg && !dec_stall;
    assign at_last  = (idx_reg == grp_reg.last_idx);
    assign room     = !busy_reg || (take && at_last);
    assign enc_stall = !room;
    assign enc_take = enc_valid && room;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (enc_take)
        begin
            busy_next = grp.emit;
            idx_next  = '0;
        end
        else if (take)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_reg <= '0;
        end
        else if (enc_take)
        begin
            grp_reg <= grp;
        end
    end

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = grp_reg.bytes[23:16];
            2'd1:    sel_byte = grp_reg.bytes[15:8];
            default: sel_byte = grp_reg.bytes[7:0];
        endcase
    end

    assign dec_valid              = busy_reg;
    assign dec_data.data_byte     = grp_reg.has_bytes ? sel_byte : 8'd0;
    assign dec_data.byte_valid    = grp_reg.has_bytes;
    assign dec_data.end_of_stream = grp_reg.eos && at_last;
    assign dec_data.status        = (grp_reg.eos && at_last) ? grp_reg.status : b64d_pkg::ST_OK;

endmodule

>>> src/b64d_checker.sv
// ----------------------------------------------------------------------------
// Base64 decoder port checker
// Watches the unit's ports and flags malformed result beats.
// ----------------------------------------------------------------------------
module b64d_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                enc_valid,
    input logic                enc_stall,
    input b64d_pkg::enc_beat_t enc_data,
    input logic                dec_valid,
    input logic                dec_stall,
    input b64d_pkg::dec_beat_t dec_data
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_stall |=> dec_valid && $stable(dec_data))
        else $error("result beat changed while stalled");

    // empty result only closes a stream
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_data.byte_valid |-> dec_data.end_of_stream && dec_data.data_byte == 8'd0)
        else $error("empty result beat without end of stream");

    a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_data.status != b64d_pkg::ST_OK |-> dec_data.end_of_stream)
        else $error("status reported before end of stream");

    // last char taken: a result beat is valid in the next cycle
    a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        enc_valid && !enc_stall && enc_data.last_char |=> dec_valid)
        else $error("no result after last character");

endmodule

bind base64_decoder_unit b64d_checker u_b64d_checker (.*);
